// ===== sv/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants for the DER tag-length-value stream parser: result kinds,
// error codes and length field limits.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned MAX_LEN_OCTETS = 4;
  localparam int unsigned LEN_W          = 32;
  localparam int unsigned OCT_W          = 3;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_OBJECT  = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd2;
  localparam logic [2:0] ERR_BAD_COUNT  = 3'd3;
  localparam logic [2:0] ERR_INDEFINITE = 3'd4;

  localparam logic [7:0] LEN_LONG_FLAG  = 8'h80;

endpackage

// ===== sv/der_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// der_tlv_stream_parser
// Byte-serial ASN.1 BER/DER TLV parser: emits one header request per object, then its
// value bytes if read_value is set, or an error request on a malformed or ended stream.
// ----------------------------------------------------------------------------
// Each result is registered when its input byte is accepted.
// Throughput: one byte per cycle unless stalled; the parse state updates in a single pass.
// in_ready drops only while the output register is full and out_ready is low.
// Reset (rst_n low, synchronous): parser waits for a tag, output empty,
// read_value set to 1.
module der_tlv_stream_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_read_value,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_tag,
  output logic [dtp_pkg::LEN_W-1:0]     out_length,
  output logic [dtp_pkg::OCT_W-1:0]     out_length_octets,
  output logic [7:0]                    out_value_byte,
  output logic                          out_last_value,
  output logic [2:0]                    out_error_code
);
  import dtp_pkg::*;

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_OCT, PH_VAL} phase_t;

  phase_t             phase_r, phase_nxt;
  logic               read_value_r;
  logic [7:0]         held_tag_r, held_tag_nxt;
  logic [LEN_W-1:0]   len_acc_r, len_acc_nxt;
  logic [OCT_W-1:0]   oct_total_r, oct_total_nxt;
  logic [OCT_W-1:0]   oct_left_r, oct_left_nxt;
  logic [LEN_W-1:0]   value_left_r, value_left_nxt;

  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [7:0]         tag_r;
  logic [LEN_W-1:0]   length_r;
  logic [OCT_W-1:0]   octs_r;
  logic [7:0]         vbyte_r;
  logic               last_r;
  logic [2:0]         err_r;

  logic               res_vld;
  logic [1:0]         res_kind;
  logic [7:0]         res_tag;
  logic [LEN_W-1:0]   res_length;
  logic [OCT_W-1:0]   res_octs;
  logic [7:0]         res_vbyte;
  logic               res_last;
  logic [2:0]         res_err;

  logic               in_acc;
  logic [6:0]         len_cnt;
  logic [LEN_W-1:0]   acc_shift;
  logic [LEN_W-1:0]   vl_dec;
  logic [OCT_W-1:0]   ol_dec;
  logic               go_value;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  assign len_cnt   = in_byte[6:0];
  assign acc_shift = {len_acc_r[LEN_W-9:0], in_byte};
  assign vl_dec    = value_left_r - LEN_W'(1);
  assign ol_dec    = oct_left_r - OCT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    held_tag_nxt   = held_tag_r;
    len_acc_nxt    = len_acc_r;
    oct_total_nxt  = oct_total_r;
    oct_left_nxt   = oct_left_r;
    value_left_nxt = value_left_r;
    res_vld        = 1'b0;
    res_kind       = KIND_HEADER;
    res_tag        = held_tag_r;
    res_length     = '0;
    res_octs       = '0;
    res_vbyte      = '0;
    res_last       = 1'b0;
    res_err        = ERR_NONE;
    go_value       = 1'b0;

    if (in_end_of_input) begin
      res_vld   = 1'b1;
      res_kind  = KIND_ERROR;
      phase_nxt = PH_TAG;
      if (phase_r == PH_TAG) begin
        res_tag = '0;
        res_err = ERR_NO_OBJECT;
      end else begin
        res_err = ERR_TRUNCATED;
      end
    end else begin
      case (phase_r)
        PH_TAG: begin
          held_tag_nxt = in_byte;
          phase_nxt    = PH_LEN;
        end
        PH_LEN: begin
          if (in_byte == LEN_LONG_FLAG) begin
            res_vld   = 1'b1;
            res_kind  = KIND_ERROR;
            res_err   = ERR_INDEFINITE;
            phase_nxt = PH_TAG;
          end else if (in_byte[7]) begin
            if (len_cnt > 7'(MAX_LEN_OCTETS)) begin
              res_vld   = 1'b1;
              res_kind  = KIND_ERROR;
              res_err   = ERR_BAD_COUNT;
              phase_nxt = PH_TAG;
            end else begin
              oct_total_nxt = len_cnt[OCT_W-1:0];
              oct_left_nxt  = len_cnt[OCT_W-1:0];
              len_acc_nxt   = '0;
              phase_nxt     = PH_OCT;
            end
          end else begin
            len_acc_nxt   = LEN_W'(in_byte);
            oct_total_nxt = '0;
            oct_left_nxt  = '0;
            res_vld       = 1'b1;
            go_value      = 1'b1;
          end
        end
        PH_OCT: begin
          len_acc_nxt  = acc_shift;
          oct_left_nxt = ol_dec;
          if (ol_dec == '0) begin
            res_vld  = 1'b1;
            go_value = 1'b1;
          end
        end
        PH_VAL: begin
          value_left_nxt = vl_dec;
          res_vld        = 1'b1;
          res_kind       = KIND_VALUE;
          res_length     = len_acc_r;
          res_octs       = oct_total_r;
          res_vbyte      = in_byte;
          res_last       = (vl_dec == '0);
          if (vl_dec == '0) begin
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase

      // header request: decide whether value bytes follow
      if (go_value) begin
        res_kind   = KIND_HEADER;
        res_length = len_acc_nxt;
        res_octs   = oct_total_nxt;
        if (read_value_r && (len_acc_nxt != '0)) begin
          value_left_nxt = len_acc_nxt;
          phase_nxt      = PH_VAL;
        end else begin
          value_left_nxt = '0;
          phase_nxt      = PH_TAG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      read_value_r <= 1'b1;
      held_tag_r   <= '0;
      len_acc_r    <= '0;
      oct_total_r  <= '0;
      oct_left_r   <= '0;
      value_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        read_value_r <= cfg_read_value;
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        held_tag_r   <= held_tag_nxt;
        len_acc_r    <= len_acc_nxt;
        oct_total_r  <= oct_total_nxt;
        oct_left_r   <= oct_left_nxt;
        value_left_r <= value_left_nxt;
        out_valid_r  <= res_vld;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc && res_vld) begin
      kind_r   <= res_kind;
      tag_r    <= res_tag;
      length_r <= res_length;
      octs_r   <= res_octs;
      vbyte_r  <= res_vbyte;
      last_r   <= res_last;
      err_r    <= res_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_tag           = tag_r;
  assign out_length        = length_r;
  assign out_length_octets = octs_r;
  assign out_value_byte    = vbyte_r;
  assign out_last_value    = last_r;
  assign out_error_code    = err_r;

`ifndef SYNTHESIS
  a_err_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_vld && res_kind == KIND_ERROR) |=> (phase_r == PH_TAG))
    else $error("parser not back at tag after error");

  a_val_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VAL) |-> (value_left_r != '0))
    else $error("value phase with nothing left");

  a_oct_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OCT) |-> (oct_left_r != '0 && oct_left_r <= oct_total_r))
    else $error("length octet count out of range");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled without output backpressure");
`endif

endmodule
